[hw/rtl/rhc_pkg.sv]
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int RGB_W = 8;
    localparam int HSL_W = 11;

    // restoring divider: one quotient bit per stage
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_LAT   = DIV_NUM_W;

    localparam logic [1:0] MODE_RGB2HSL = 2'd0;
    localparam logic [1:0] MODE_HSL2RGB = 2'd1;
    localparam logic [1:0] MODE_COMPL   = 2'd2;

    localparam int THIRD_TURN     = 341;
    localparam int TWO_THIRD_TURN = 682;
    localparam int FULL_TURN      = 1024;
    localparam int HALF_TURN      = 512;

    typedef struct packed {
        logic [RGB_W-1:0] red_in;
        logic [RGB_W-1:0] green_in;
        logic [RGB_W-1:0] blue_in;
        logic [HSL_W-1:0] hue_in;
        logic [HSL_W-1:0] saturation_in;
        logic [HSL_W-1:0] lightness_in;
    } in_item_t;

    typedef struct packed {
        logic [RGB_W-1:0] red_out;
        logic [RGB_W-1:0] green_out;
        logic [RGB_W-1:0] blue_out;
        logic [HSL_W-1:0] hue_out;
        logic [HSL_W-1:0] saturation_out;
        logic [HSL_W-1:0] lightness_out;
    } out_item_t;

    // hue, saturation, lightness heading into the rgb back end
    typedef struct packed {
        logic [1:0]       mode;
        logic [HSL_W-1:0] h;
        logic [HSL_W-1:0] s;
        logic [HSL_W-1:0] l;
    } conv_t;

    // data riding alongside the dividers
    typedef struct packed {
        logic [1:0]       mode;
        logic [HSL_W-1:0] hue_in;
        logic [HSL_W-1:0] sat_in;
        logic [HSL_W-1:0] light_in;
        logic             rmax;
        logic             gmax;
        logic             grey;
        logic [HSL_W-1:0] light;
    } side_t;

endpackage

[hw/rtl/rhc_if.sv]
`timescale 1ns / 1ps

interface rhc_in_if;
    logic               valid;
    logic               ready;
    rhc_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rhc_out_if;
    logic               valid;
    logic               ready;
    rhc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rhc_divider.sv]
`timescale 1ns / 1ps

module rhc_divider #(
    parameter int NUM_W = rhc_pkg::DIV_NUM_W,
    parameter int DEN_W = rhc_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] num_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];
    logic [DEN_W-1:0] den_next [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [DEN_W-1:0] rem_prev;
            logic [NUM_W-1:0] num_prev;
            logic [NUM_W-1:0] quo_prev;
            logic [DEN_W-1:0] den_prev;
            logic [DEN_W:0]   trial;

            if (k == 0) begin : g_first
                assign rem_prev = '0;
                assign num_prev = num;
                assign quo_prev = '0;
                assign den_prev = den;
            end else begin : g_next
                assign rem_prev = rem_reg[k-1];
                assign num_prev = num_reg[k-1];
                assign quo_prev = quo_reg[k-1];
                assign den_prev = den_reg[k-1];
            end

            always_comb
            begin
                trial       = {rem_prev, num_prev[NUM_W-1]};
                den_next[k] = den_prev;
                num_next[k] = {num_prev[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den_prev})
                begin
                    rem_next[k] = DEN_W'(trial - {1'b0, den_prev});
                    quo_next[k] = {quo_prev[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = trial[DEN_W-1:0];
                    quo_next[k] = {quo_prev[NUM_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next[k];
                    num_reg[k] <= num_next[k];
                    quo_reg[k] <= quo_next[k];
                    den_reg[k] <= den_next[k];
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NUM_W-1];

endmodule

[hw/rtl/rhc_hsl2rgb.sv]
`timescale 1ns / 1ps

module rhc_hsl2rgb (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rhc_pkg::conv_t     conv,
    output logic               out_valid,
    output rhc_pkg::out_item_t item
);

    typedef enum logic [1:0] {RAMP_UP, RAMP_HI, RAMP_DOWN, RAMP_LO} ramp_t;

    typedef struct packed {
        ramp_t              ramp;
        logic signed [15:0] a;
        logic signed [14:0] m;
    } lane_t;

    localparam logic signed [12:0] LANE_OFS [3] = '{13'sd341, 13'sd0, -13'sd341};

    // stage 1: l*s
    logic           h1_valid_reg;
    rhc_pkg::conv_t h1_conv_reg;
    logic [21:0]    h1_ls_reg;

    // stage 2: hi/lo and lane operands
    logic               h2_valid_reg;
    rhc_pkg::conv_t     h2_conv_reg;
    logic signed [15:0] h2_hi_reg, h2_lo_reg;
    lane_t              h2_lane_reg [3];
    logic signed [15:0] hi_next, lo_next, diff;
    lane_t              lane_next [3];

    // stage 3: products
    logic               h3_valid_reg;
    rhc_pkg::conv_t     h3_conv_reg;
    logic signed [15:0] h3_hi_reg, h3_lo_reg;
    ramp_t              h3_ramp_reg [3];
    logic signed [30:0] h3_p1_reg [3];
    logic signed [30:0] h3_p2_reg [3];

    // stage 4: output
    logic               out_valid_reg;
    rhc_pkg::out_item_t out_reg, out_next;
    logic [7:0]         byte_ch [3];
    logic signed [31:0] v_ch [3];

    logic signed [15:0] l16, s16, lsh16;
    logic signed [12:0] hc [3];
    logic [10:0]        hw [3];
    logic [12:0]        t3 [3];
    logic [13:0]        w [3];

    function automatic logic [7:0] to_byte(input logic signed [31:0] v);
        logic signed [31:0] q;
        q = v >>> 2;
        if (q < 0)
            return 8'd0;
        else if (q > 32'sd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg  <= 1'b0;
            h2_valid_reg  <= 1'b0;
            h3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h1_valid_reg  <= in_valid;
            h2_valid_reg  <= h1_valid_reg;
            h3_valid_reg  <= h2_valid_reg;
            out_valid_reg <= h3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_conv_reg <= conv;
            h1_ls_reg   <= conv.l * conv.s;
        end
    end

    always_comb
    begin
        l16   = $signed({5'b0, h1_conv_reg.l});
        s16   = $signed({5'b0, h1_conv_reg.s});
        lsh16 = $signed({4'b0, h1_ls_reg[21:10]});
        if (h1_conv_reg.l < 11'(rhc_pkg::HALF_TURN))
            hi_next = l16 + lsh16;
        else
            hi_next = l16 + s16 - lsh16;
        lo_next = (l16 <<< 1) - hi_next;
        diff    = hi_next - lo_next;
        for (int i = 0; i < 3; i++)
        begin
            hc[i] = $signed({2'b0, h1_conv_reg.h}) + LANE_OFS[i];
            if (hc[i] < 0)
                hc[i] = hc[i] + 13'(rhc_pkg::FULL_TURN);
            else if (hc[i] > 13'sd1024)
                hc[i] = hc[i] - 13'(rhc_pkg::FULL_TURN);
            hw[i] = hc[i][10:0];
            t3[i] = {2'b0, hw[i]} + {1'b0, hw[i], 1'b0};
            w[i]  = 14'd4096 - {t3[i], 1'b0};
            priority if (t3[i] < 13'd512)
            begin
                lane_next[i].ramp = RAMP_UP;
                lane_next[i].a    = hi_next;
                lane_next[i].m    = $signed({2'b0, t3[i]});
            end
            else if (hw[i] < 11'(rhc_pkg::HALF_TURN))
            begin
                lane_next[i].ramp = RAMP_HI;
                lane_next[i].a    = hi_next;
                lane_next[i].m    = '0;
            end
            else if (t3[i] < 13'd2048)
            begin
                lane_next[i].ramp = RAMP_DOWN;
                lane_next[i].a    = diff;
                lane_next[i].m    = $signed({1'b0, w[i]});
            end
            else
            begin
                lane_next[i].ramp = RAMP_LO;
                lane_next[i].a    = hi_next;
                lane_next[i].m    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h2_conv_reg <= h1_conv_reg;
            h2_hi_reg   <= hi_next;
            h2_lo_reg   <= lo_next;
            for (int i = 0; i < 3; i++)
                h2_lane_reg[i] <= lane_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h3_conv_reg <= h2_conv_reg;
            h3_hi_reg   <= h2_hi_reg;
            h3_lo_reg   <= h2_lo_reg;
            for (int i = 0; i < 3; i++)
            begin
                h3_ramp_reg[i] <= h2_lane_reg[i].ramp;
                h3_p1_reg[i]   <= h2_lane_reg[i].a * h2_lane_reg[i].m;
                h3_p2_reg[i]   <= h2_lo_reg * h2_lane_reg[i].m;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (h3_ramp_reg[i])
                RAMP_UP:   v_ch[i] = 32'(h3_lo_reg) + (32'(h3_p1_reg[i]) >>> 9)
                                     - (32'(h3_p2_reg[i]) >>> 9);
                RAMP_HI:   v_ch[i] = 32'(h3_hi_reg);
                RAMP_DOWN: v_ch[i] = 32'(h3_lo_reg) + (32'(h3_p1_reg[i]) >>> 10);
                RAMP_LO:   v_ch[i] = 32'(h3_lo_reg);
                default:   v_ch[i] = 32'(h3_lo_reg);
            endcase
            if (h3_conv_reg.s == '0)
                byte_ch[i] = to_byte($signed({21'b0, h3_conv_reg.l}));
            else
                byte_ch[i] = to_byte(v_ch[i]);
        end

        out_next = '0;
        if (h3_conv_reg.mode == rhc_pkg::MODE_RGB2HSL)
        begin
            out_next.hue_out        = h3_conv_reg.h;
            out_next.saturation_out = h3_conv_reg.s;
            out_next.lightness_out  = h3_conv_reg.l;
        end
        else if (h3_conv_reg.mode == rhc_pkg::MODE_HSL2RGB ||
                 h3_conv_reg.mode == rhc_pkg::MODE_COMPL)
        begin
            out_next.red_out   = byte_ch[0];
            out_next.green_out = byte_ch[1];
            out_next.blue_out  = byte_ch[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign item      = out_reg;

endmodule

[hw/rtl/rgb_hsl_color_converter_top.sv]
`timescale 1ns / 1ps

// RGB/HSL pixel converter, 1024 = full scale. Takes one item per clock and
// returns one result per item, in order, through the input register,
// divider setup, 18 restoring-divider stages (one quotient bit per stage
// sets the depth), hue assembly, then four stages of HSL to RGB with the
// ramp multipliers. All stages advance together whenever the output
// register is empty or being taken, so a stalled consumer holds the whole
// pipe without loss. mode_we/mode_wdata set the mode (0 rgb to hsl, 1 hsl to
// rgb, 2 complementary color, 3 all-zero result); change it only when the
// pipe is empty.
module rgb_hsl_color_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode_we,
    input  logic [1:0]  mode_wdata,
    rhc_in_if.sink      pixel,
    rhc_out_if.source   result
);

    localparam int NW  = rhc_pkg::DIV_NUM_W;
    localparam int DW  = rhc_pkg::DIV_DEN_W;
    localparam int LAT = rhc_pkg::DIV_LAT;

    logic adv;
    logic h2r_valid;

    logic [1:0] mode_reg;

    logic              a_valid_reg;
    rhc_pkg::in_item_t a_pix_reg;
    logic [1:0]        a_mode_reg;

    logic [7:0]     mx, mn, dd;
    logic [8:0]     sum;
    logic [DW-1:0]  den_s_next, den_h_next;
    rhc_pkg::side_t side_next;

    logic           b_valid_reg;
    logic [NW-1:0]  b_num_r_reg, b_num_g_reg, b_num_b_reg, b_num_s_reg;
    logic [DW-1:0]  b_den_h_reg, b_den_s_reg;
    rhc_pkg::side_t b_side_reg;

    logic [LAT-1:0] div_valid_reg;
    rhc_pkg::side_t side_reg [LAT];
    logic [NW-1:0]  q_r, q_g, q_b, q_s;

    logic signed [19:0] hue;
    logic [10:0]        h11, s11;
    rhc_pkg::side_t     sd;
    logic               c_valid_reg;
    rhc_pkg::conv_t     c_conv_reg, conv_next;

    assign adv         = !h2r_valid || result.ready;
    assign pixel.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= rhc_pkg::MODE_RGB2HSL;
        else if (mode_we)
            mode_reg <= mode_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            div_valid_reg <= '0;
            c_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= pixel.valid;
            b_valid_reg   <= a_valid_reg;
            div_valid_reg <= {div_valid_reg[LAT-2:0], b_valid_reg};
            c_valid_reg   <= div_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pix_reg  <= pixel.data;
            a_mode_reg <= mode_reg;
        end
    end

    // max/min on the raw bytes; the x4 scale cancels out of every ratio
    always_comb
    begin
        mx = a_pix_reg.red_in;
        mn = a_pix_reg.red_in;
        if (a_pix_reg.green_in > mx) mx = a_pix_reg.green_in;
        if (a_pix_reg.green_in < mn) mn = a_pix_reg.green_in;
        if (a_pix_reg.blue_in > mx)  mx = a_pix_reg.blue_in;
        if (a_pix_reg.blue_in < mn)  mn = a_pix_reg.blue_in;
        dd  = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        if (sum < 9'd256)
            den_s_next = {1'b0, sum};
        else
            den_s_next = 10'd512 - {1'b0, sum};
        den_h_next = {2'b0, dd} + {1'b0, dd, 1'b0};

        side_next.mode     = a_mode_reg;
        side_next.hue_in   = a_pix_reg.hue_in;
        side_next.sat_in   = a_pix_reg.saturation_in;
        side_next.light_in = a_pix_reg.lightness_in;
        side_next.rmax     = (a_pix_reg.red_in == mx);
        side_next.gmax     = (a_pix_reg.green_in == mx);
        side_next.grey     = (dd == '0);
        side_next.light    = {1'b0, sum, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_num_r_reg <= {1'b0, a_pix_reg.red_in, 9'b0};
            b_num_g_reg <= {1'b0, a_pix_reg.green_in, 9'b0};
            b_num_b_reg <= {1'b0, a_pix_reg.blue_in, 9'b0};
            b_num_s_reg <= {dd, 10'b0};
            b_den_h_reg <= den_h_next;
            b_den_s_reg <= den_s_next;
            b_side_reg  <= side_next;
        end
    end

    rhc_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_r (
        .clk(clk), .en(adv), .num(b_num_r_reg), .den(b_den_h_reg), .quo(q_r)
    );
    rhc_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_g (
        .clk(clk), .en(adv), .num(b_num_g_reg), .den(b_den_h_reg), .quo(q_g)
    );
    rhc_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_b (
        .clk(clk), .en(adv), .num(b_num_b_reg), .den(b_den_h_reg), .quo(q_b)
    );
    rhc_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_s (
        .clk(clk), .en(adv), .num(b_num_s_reg), .den(b_den_s_reg), .quo(q_s)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= b_side_reg;
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // the common base term drops out of each hue difference
    always_comb
    begin
        sd = side_reg[LAT-1];
        if (sd.rmax)
            hue = $signed({2'b0, q_g}) - $signed({2'b0, q_b});
        else if (sd.gmax)
            hue = 20'(rhc_pkg::THIRD_TURN) + $signed({2'b0, q_b}) - $signed({2'b0, q_r});
        else
            hue = 20'(rhc_pkg::TWO_THIRD_TURN) + $signed({2'b0, q_r})
                  - $signed({2'b0, q_g});
        if (hue < 0)
            hue = hue + 20'(rhc_pkg::FULL_TURN);
        else if (hue > 20'sd1024)
            hue = hue - 20'(rhc_pkg::FULL_TURN);
        h11 = hue[10:0];
        s11 = q_s[10:0];
        if (sd.grey)
        begin
            h11 = '0;
            s11 = '0;
        end

        conv_next.mode = sd.mode;
        if (sd.mode == rhc_pkg::MODE_HSL2RGB)
        begin
            conv_next.h = sd.hue_in;
            conv_next.s = sd.sat_in;
            conv_next.l = sd.light_in;
        end
        else if (sd.mode == rhc_pkg::MODE_COMPL)
        begin
            conv_next.h = h11 + 11'(rhc_pkg::HALF_TURN);
            conv_next.s = s11;
            conv_next.l = sd.light;
        end
        else
        begin
            conv_next.h = h11;
            conv_next.s = s11;
            conv_next.l = sd.light;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c_conv_reg <= conv_next;
    end

    rhc_hsl2rgb u_hsl2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .conv      (c_conv_reg),
        .out_valid (h2r_valid),
        .item      (result.data)
    );

    assign result.valid = h2r_valid;

endmodule

[verif/tb_rgb_hsl_color_converter_top.sv]
`timescale 1ns / 1ps

module tb_rgb_hsl_color_converter_top;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       mode_we = 1'b0;
    logic [1:0] mode_wdata = 2'd0;

    rhc_in_if  pixel();
    rhc_out_if result();

    rgb_hsl_color_converter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .pixel      (pixel.sink),
        .result     (result.source)
    );

    always #6 clk = ~clk;

    localparam int LATENCY = 25;
    localparam int STALL_LIMIT = 2000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    rhc_pkg::in_item_t  pixel_q[$];
    rhc_pkg::out_item_t expected_q[$];
    logic [1:0] cur_mode;
    bit   send_idle_en = 1'b1;
    bit   recv_idle_en = 1'b1;
    bit   hold_send = 1'b0;
    int   errors = 0;
    int   stall_cycles = 0;

    function automatic longint floor_shr(longint v, int n);
        if (v >= 0)
            return v >>> n;
        return -(((-v) - 1) >>> n) - 1;
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        longint q;
        q = floor_shr(v, 2);
        if (q < 0)
            return 8'd0;
        if (q > 255)
            return 8'd255;
        return q[7:0];
    endfunction

    function automatic void rgb2hsl(input logic [7:0] r8, g8, b8,
                                    output longint h, s, l);
        longint r, g, b, mn, mx, d, base, dr, dg, db, hue;
        r = r8 * 4;
        g = g8 * 4;
        b = b8 * 4;
        mn = (r < g) ? r : g;
        mx = (r > g) ? r : g;
        if (b < mn) mn = b;
        if (b > mx) mx = b;
        d = mx - mn;
        l = (mx + mn) >>> 1;
        h = 0;
        s = 0;
        if (d != 0)
        begin
            if (l < 512)
                s = (d * 1024) / (mx + mn);
            else
                s = (d * 1024) / (2048 - mx - mn);
            base = (mx * 512) / 3 / d + 512;
            dr = base - ((r * 512) / 3) / d;
            dg = base - ((g * 512) / 3) / d;
            db = base - ((b * 512) / 3) / d;
            if (r == mx)
                hue = db - dg;
            else if (g == mx)
                hue = rhc_pkg::THIRD_TURN + dr - db;
            else
                hue = rhc_pkg::TWO_THIRD_TURN + dg - dr;
            if (hue < 0)
                hue += 1024;
            else if (hue > 1024)
                hue -= 1024;
            h = hue;
        end
    endfunction

    function automatic longint ramp(longint lo, longint hi, longint h);
        longint t, w;
        if (h < 0)
            h += 1024;
        else if (h > 1024)
            h -= 1024;
        t = 3 * h;
        if (t < 512)
            return lo + (floor_shr(3 * hi * h, 9) - floor_shr(3 * lo * h, 9));
        if (h < 512)
            return hi;
        if (t < 2048)
        begin
            w = 4096 - 2 * t;
            return lo + floor_shr(hi * w - lo * w, 10);
        end
        return lo;
    endfunction

    function automatic void hsl2rgb(input longint h, s, l,
                                    inout rhc_pkg::out_item_t o);
        longint hi, lo;
        if (s == 0)
        begin
            o.red_out = clamp_byte(l);
            o.green_out = clamp_byte(l);
            o.blue_out = clamp_byte(l);
        end
        else
        begin
            if (l < 512)
                hi = l + ((l * s) >>> 10);
            else
                hi = l + s - ((l * s) >>> 10);
            lo = 2 * l - hi;
            o.red_out = clamp_byte(ramp(lo, hi, h + rhc_pkg::THIRD_TURN));
            o.green_out = clamp_byte(ramp(lo, hi, h));
            o.blue_out = clamp_byte(ramp(lo, hi, h - rhc_pkg::THIRD_TURN));
        end
    endfunction

    function automatic rhc_pkg::out_item_t convert_pixel(rhc_pkg::in_item_t p,
                                                         logic [1:0] mode);
        rhc_pkg::out_item_t o;
        longint h, s, l;
        o = '0;
        case (mode)
            rhc_pkg::MODE_RGB2HSL:
            begin
                rgb2hsl(p.red_in, p.green_in, p.blue_in, h, s, l);
                o.hue_out = h[10:0];
                o.saturation_out = s[10:0];
                o.lightness_out = l[10:0];
            end
            rhc_pkg::MODE_HSL2RGB:
                hsl2rgb(p.hue_in, p.saturation_in, p.lightness_in, o);
            rhc_pkg::MODE_COMPL:
            begin
                rgb2hsl(p.red_in, p.green_in, p.blue_in, h, s, l);
                h = (h + rhc_pkg::HALF_TURN) & 'h7ff;
                hsl2rgb(h, s, l, o);
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel.valid <= 1'b0;
            pixel.data <= '0;
        end
        else
        begin
            if (!pixel.valid || pixel.ready)
            begin
                if (pixel.valid)
                    expected_q.push_back(convert_pixel(pixel.data, cur_mode));
                if (pixel_q.size() > 0 && !hold_send &&
                    !(send_idle_en && $urandom_range(99) < 11))
                begin
                    pixel.valid <= 1'b1;
                    pixel.data <= pixel_q.pop_front();
                end
                else
                    pixel.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rhc_pkg::out_item_t e, a;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                a = result.data;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item %p", a);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (a.red_out !== e.red_out)
                        $error("red_out exp %0d got %0d", e.red_out, a.red_out);
                    if (a.green_out !== e.green_out)
                        $error("green_out exp %0d got %0d", e.green_out, a.green_out);
                    if (a.blue_out !== e.blue_out)
                        $error("blue_out exp %0d got %0d", e.blue_out, a.blue_out);
                    if (a.hue_out !== e.hue_out)
                        $error("hue_out exp %0d got %0d", e.hue_out, a.hue_out);
                    if (a.saturation_out !== e.saturation_out)
                        $error("saturation_out exp %0d got %0d",
                               e.saturation_out, a.saturation_out);
                    if (a.lightness_out !== e.lightness_out)
                        $error("lightness_out exp %0d got %0d",
                               e.lightness_out, a.lightness_out);
                    if (a !== e)
                        errors++;
                end
            end
            result.ready <= !(recv_idle_en && $urandom_range(99) < 11);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((pixel.valid && pixel.ready) || (result.valid && result.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic rhc_pkg::in_item_t rand_pixel(bit wide_hsl);
        rhc_pkg::in_item_t p;
        p.red_in = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in = 8'($urandom);
        if (wide_hsl)
        begin
            p.hue_in = 11'($urandom);
            p.saturation_in = 11'($urandom);
            p.lightness_in = 11'($urandom);
        end
        else
        begin
            p.hue_in = 11'($urandom_range(1024));
            p.saturation_in = 11'($urandom_range(1024));
            p.lightness_in = 11'($urandom_range(1024));
        end
        return p;
    endfunction

    function automatic rhc_pkg::in_item_t make_pixel(logic [7:0] r, g, b,
                                                     logic [10:0] h, s, l);
        rhc_pkg::in_item_t p;
        p.red_in = r;
        p.green_in = g;
        p.blue_in = b;
        p.hue_in = h;
        p.saturation_in = s;
        p.lightness_in = l;
        return p;
    endfunction

    task automatic drain();
        wait (pixel_q.size() == 0);
        @(posedge clk);
        while (pixel.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        mode_we <= 1'b1;
        mode_wdata <= m;
        cur_mode = m;
        @(posedge clk);
        mode_we <= 1'b0;
    endtask

    task automatic directed_set();
        pixel_q.push_back(make_pixel(0, 0, 0, 0, 0, 0));
        pixel_q.push_back(make_pixel(255, 255, 255, 1024, 1024, 1024));
        pixel_q.push_back(make_pixel(128, 128, 128, 512, 0, 512));
        pixel_q.push_back(make_pixel(255, 0, 0, 0, 1024, 512));
        pixel_q.push_back(make_pixel(0, 255, 0, 341, 1024, 512));
        pixel_q.push_back(make_pixel(0, 0, 255, 682, 1024, 512));
        pixel_q.push_back(make_pixel(255, 0, 255, 1023, 512, 300));
        pixel_q.push_back(make_pixel(255, 255, 0, 170, 700, 800));
        pixel_q.push_back(make_pixel(1, 0, 0, 2047, 2047, 2047));
        pixel_q.push_back(make_pixel(254, 255, 255, 1500, 1024, 511));
        pixel_q.push_back(make_pixel(10, 200, 90, 1025, 3, 1));
    endtask

    initial
    begin
        int i;
        logic [1:0] mode_seq[6];
        mode_seq = '{rhc_pkg::MODE_RGB2HSL, rhc_pkg::MODE_HSL2RGB, rhc_pkg::MODE_COMPL,
                     MODE_UNUSED, rhc_pkg::MODE_COMPL, rhc_pkg::MODE_HSL2RGB};
        cur_mode = rhc_pkg::MODE_RGB2HSL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (mode_seq[k])
        begin
            set_mode(mode_seq[k]);
            directed_set();
            // a stretch with no idling in the third phase
            send_idle_en = (k != 2);
            recv_idle_en = (k != 2);
            for (i = 0; i < 340; i++)
                pixel_q.push_back(rand_pixel($urandom_range(3) == 0));
            if (k == 1)
            begin
                wait (pixel_q.size() < 150);
                // hold the sender until the pipe is empty
                hold_send = 1'b1;
                while (expected_q.size() > 0 || pixel.valid)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            drain();
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
